@@ sv/ssr_pkg.sv @@
// shared types and constants for the substring replace block
// used by ssr_cell and substring_replace_core; depends on nothing
`default_nettype none

package ssr_pkg;

    // widest window the block ever keeps, and the width of a count over it
    localparam int WIN_MAX = 8;
    localparam int CNT_W   = $clog2(WIN_MAX + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET_BYTES       = 2'd0;
    localparam logic [1:0] CFG_TARGET_LENGTH      = 2'd1;
    localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    // output sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPL,
        ST_FLUSH
    } t_state;

    // control broadcast to every window cell
    typedef struct packed {
        logic             shift;   // every cell takes its right neighbor's view
        logic             append;  // the incoming byte lands at position count
        logic [CNT_W-1:0] count;   // bytes held before this transfer
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/ssr_cell.sv @@
// one byte cell of the pending window chain
// depends on ssr_pkg for the cell control struct
`default_nettype none

module ssr_cell #(
    parameter int IDX = 0
) (
    input  wire logic                i_clk,
    input  wire ssr_pkg::t_cell_ctl  i_ctl,
    input  wire logic [7:0]          i_byte,
    input  wire logic [7:0]          i_nbr,
    input  wire logic [7:0]          i_tgt,
    output logic [7:0]               o_view,
    output logic                     o_eq
);
    import ssr_pkg::*;

    localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       load;

    // this cell is the append slot for the current transfer
    assign load   = i_ctl.append && (i_ctl.count == POS);
    assign o_view = load ? i_byte : r_byte;
    assign o_eq   = (o_view == i_tgt);

    // shift from the neighbor, take the new byte, or hold
    always_comb begin
        if (i_ctl.shift) begin
            n_byte = i_nbr;
        end else if (load) begin
            n_byte = i_byte;
        end else begin
            n_byte = r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

`default_nettype wire

@@ sv/substring_replace_core.sv @@
// Streaming find-and-replace-all over a byte string.
// A result appears on the output register in the cycle after the transfer that causes it.
// Throughput: one input byte per cycle while each byte causes at most one result and the output
// is not stalled; a byte that causes k results (replacement burst or end-of-string flush)
// holds input until all are out; the single output register moves one result byte per cycle.
// Reset (synchronous, active low) clears window count, sequencer, output valid and configuration.
`default_nettype none

module substring_replace_core #(
    parameter int MAX_TARGET      = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_string,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_last_of_string
);
    import ssr_pkg::*;

    localparam int DEPTH = (MAX_TARGET < WIN_MAX) ? MAX_TARGET : WIN_MAX;
    localparam int RKEEP = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
    localparam int TCW   = $clog2(DEPTH + 1);
    localparam int RCW   = $clog2(RKEEP + 1);
    localparam int RIW   = (RKEEP > 1) ? $clog2(RKEEP) : 1;

    // configuration
    logic [7:0]     r_tgt [DEPTH];
    logic [7:0]     r_repl [RKEEP];
    logic [TCW-1:0] r_tl;
    logic [RCW-1:0] r_rl;

    // window and sequencer state
    t_state         r_state, n_state;
    logic [TCW-1:0] r_count, n_count;
    logic [RCW-1:0] r_idx, n_idx;
    logic           r_eos, n_eos;

    // output register
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_bv;
    logic           r_out_last;

    // cell chain
    t_cell_ctl      ctl;
    logic [7:0]     view [DEPTH];
    logic [7:0]     nbr [DEPTH];
    logic [DEPTH-1:0] eq;

    // decisions
    logic           out_free;
    logic           accept;
    logic           full;
    logic           hit;
    logic           go_hit;
    logic           go_slide;
    logic           emit;
    logic [7:0]     e_byte;
    logic           e_bv;
    logic           e_last;

    // window cells, each handing its view to the left neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g + 1 < DEPTH) begin : g_mid
            assign nbr[g] = view[g + 1];
        end else begin : g_end
            assign nbr[g] = 8'd0;
        end
        ssr_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_byte (i_data_byte),
            .i_nbr  (nbr[g]),
            .i_tgt  (r_tgt[g]),
            .o_view (view[g]),
            .o_eq   (eq[g])
        );
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // window reaches target length with this byte, and the compare over it
    assign full = ((TCW+1)'(r_count) + (TCW+1)'(1)) >= (TCW+1)'(r_tl);

    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            if ((TCW'(i) < r_tl) && !eq[i]) begin
                hit = 1'b0;
            end
        end
    end

    assign go_hit   = accept && (r_tl != '0) && full && hit;
    assign go_slide = accept && (r_tl != '0) && !(full && hit) && (full || i_end_of_string);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go_hit && (r_rl > RCW'(1))) begin
                    n_state = ST_REPL;
                end else if (go_slide && i_end_of_string && (r_count != '0)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_REPL: begin
                if (out_free && (r_idx == r_rl - RCW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free && (r_count == TCW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // emitted result, cell control and counters
    always_comb begin
        emit       = 1'b0;
        e_byte     = 8'd0;
        e_bv       = 1'b1;
        e_last     = 1'b0;
        ctl.shift  = 1'b0;
        ctl.append = 1'b0;
        ctl.count  = CNT_W'(r_count);
        n_count    = r_count;
        n_idx      = r_idx;
        n_eos      = r_eos;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_tl == '0) begin
                        // pass through
                        emit    = 1'b1;
                        e_byte  = i_data_byte;
                        e_last  = i_end_of_string;
                        n_count = '0;
                    end else begin
                        ctl.append = 1'b1;
                        if (full && hit) begin
                            n_count = '0;
                            n_idx   = RCW'(1);
                            n_eos   = i_end_of_string;
                            if (r_rl != '0) begin
                                emit   = 1'b1;
                                e_byte = r_repl[0];
                                e_last = i_end_of_string && (r_rl == RCW'(1));
                            end else if (i_end_of_string) begin
                                // bare end marker
                                emit   = 1'b1;
                                e_bv   = 1'b0;
                                e_last = 1'b1;
                            end
                        end else if (full || i_end_of_string) begin
                            // oldest byte leaves, the rest slides down
                            emit      = 1'b1;
                            e_byte    = view[0];
                            e_last    = i_end_of_string && (r_count == '0);
                            ctl.shift = 1'b1;
                        end else begin
                            n_count = r_count + TCW'(1);
                        end
                    end
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_byte = r_repl[r_idx[RIW-1:0]];
                    e_last = r_eos && (r_idx == r_rl - RCW'(1));
                    n_idx  = r_idx + RCW'(1);
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_byte    = view[0];
                    e_last    = (r_count == TCW'(1));
                    ctl.shift = 1'b1;
                    n_count   = r_count - TCW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer and window count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_eos   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_eos   <= n_eos;
            if (i_cfg_we && (i_cfg_index == CFG_TARGET_LENGTH)) begin
                r_count <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

    // configuration registers, lengths clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl <= '0;
            r_rl <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_tgt[k] <= 8'd0;
            end
            for (int k = 0; k < RKEEP; k++) begin
                r_repl[k] <= 8'd0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_BYTES: begin
                    for (int k = 0; k < DEPTH; k++) begin
                        r_tgt[k] <= i_cfg_data[8*k +: 8];
                    end
                end
                CFG_TARGET_LENGTH: begin
                    r_tl <= (i_cfg_data[3:0] > 4'(DEPTH)) ? TCW'(DEPTH) : TCW'(i_cfg_data[3:0]);
                end
                CFG_REPLACEMENT_BYTES: begin
                    for (int k = 0; k < RKEEP; k++) begin
                        r_repl[k] <= i_cfg_data[8*k +: 8];
                    end
                end
                CFG_REPLACEMENT_LENGTH: begin
                    r_rl <= (i_cfg_data[3:0] > 4'(RKEEP)) ? RCW'(RKEEP) : RCW'(i_cfg_data[3:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_bv   <= e_bv;
            r_out_last <= e_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_out_bv;
    assign o_last_of_string = r_out_last;

endmodule

`default_nettype wire
